@@ hw/rtl/twcs_pkg.sv @@
package twcs_pkg;

    localparam int TEX_SIZE_DEF      = 64;
    localparam int SCREEN_HEIGHT_DEF = 512;

    localparam logic [31:0] SHADE_MASK = 32'h007F_7F7F;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DRAW = 1'b1;

    localparam logic REG_CEILING = 1'b0;
    localparam logic REG_FLOOR   = 1'b1;

    localparam int ITEM_W     = 90;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 56;

    // first field sits in the highest bits
    typedef struct packed {
        logic [31:0]       load_color;
        logic [5:0]        load_row;
        logic [1:0]        load_tex;
        logic signed [7:0] tex_col;
        logic              ray_dir_y_pos;
        logic              ray_dir_x_pos;
        logic              side;
        logic [9:0]        wall_end;
        logic [9:0]        wall_start;
        logic [8:0]        screen_y;
        logic [9:0]        screen_x;
    } twcs_item_t;

    typedef struct packed {
        logic accept;
        logic start_div;
        logic load_step;
        logic read_tex;
        logic take_cfg_color;
        logic take_texel;
        logic load_out;
    } twcs_cmd_t;

    typedef struct packed {
        logic req_draw;
        logic drop;
        logic floor_row;
        logic ceil_row;
        logic first_row;
        logic div_done;
        logic visible;
        logic out_free;
    } twcs_status_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b000_0001,
        ST_CHECK = 7'b000_0010,
        ST_DIV   = 7'b000_0100,
        ST_MUL   = 7'b000_1000,
        ST_READ  = 7'b001_0000,
        ST_FETCH = 7'b010_0000,
        ST_EMIT  = 7'b100_0000
    } twcs_state_t;

endpackage

@@ hw/rtl/twcs_ram.sv @@
module twcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/twcs_divider.sv @@
module twcs_divider #(
    parameter int TEX_SIZE = twcs_pkg::TEX_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [9:0]  divisor,
    output logic        done,
    output logic [31:0] quotient
);
    import twcs_pkg::*;

    localparam int DW = $clog2(TEX_SIZE) + 17;
    localparam int CW = $clog2(DW + 1);
    localparam logic [DW-1:0] DIVIDEND = DW'(64'(TEX_SIZE) << 16);

    logic [DW-1:0] dividend_reg;
    logic [DW-1:0] quot_reg;
    logic [9:0]    rem_reg;
    logic [9:0]    divisor_reg;
    logic [CW-1:0] count_reg;
    logic          busy_reg;
    logic [10:0]   trial;
    logic          fits;

    assign trial = {rem_reg, dividend_reg[DW-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    // one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            count_reg <= CW'(DW);
        end else if (busy_reg) begin
            count_reg <= count_reg - CW'(1);
            if (count_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dividend_reg <= DIVIDEND;
            quot_reg     <= '0;
            rem_reg      <= '0;
            divisor_reg  <= divisor;
        end else if (busy_reg) begin
            dividend_reg <= {dividend_reg[DW-2:0], 1'b0};
            quot_reg     <= {quot_reg[DW-2:0], fits};
            rem_reg      <= fits ? 10'(trial - {1'b0, divisor_reg}) : trial[9:0];
        end
    end

    assign done     = !busy_reg;
    assign quotient = 32'(quot_reg);

endmodule

@@ hw/rtl/twcs_datapath.sv @@
module twcs_datapath #(
    parameter int TEX_SIZE      = twcs_pkg::TEX_SIZE_DEF,
    parameter int SCREEN_HEIGHT = twcs_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  twcs_pkg::twcs_item_t   item,
    input  logic                   req_type,
    input  logic [31:0]            ceil_rgb,
    input  logic [31:0]            floor_rgb,
    input  twcs_pkg::twcs_cmd_t    cmd,
    output twcs_pkg::twcs_status_t status,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [9:0]             out_x,
    output logic [8:0]             out_y,
    output logic [31:0]            out_color
);
    import twcs_pkg::*;

    localparam int LOG    = $clog2(TEX_SIZE);
    localparam int ADDR_W = 2 + 2 * LOG;
    localparam logic [31:0] HALF_H = 32'(SCREEN_HEIGHT / 2);

    twcs_item_t  item_reg;
    logic [31:0] step_reg;
    logic [31:0] pos_reg;
    logic [31:0] color_reg;
    logic        m_tvalid_reg;
    logic [9:0]  out_x_reg;
    logic [8:0]  out_y_reg;
    logic [31:0] out_color_reg;

    logic              wr_ok;
    logic [15:0]       wcol16;
    logic [15:0]       wrow16;
    logic [ADDR_W-1:0] waddr;
    logic              col_ok;
    logic [15:0]       col16;
    logic [9:0]        height;
    logic              div_done;
    logic [31:0]       quotient;
    logic [31:0]       base;
    logic [63:0]       product;
    logic [31:0]       neg_pos;
    logic [15:0]       neg_whole;
    logic [LOG-1:0]    row;
    logic [1:0]        tex_sel;
    logic [ADDR_W-1:0] raddr;
    logic [31:0]       rdata;
    logic [31:0]       texel;
    logic              out_free;

    // texel load straight from the input beat
    assign wcol16 = {8'b0, item.tex_col};
    assign wrow16 = {10'b0, item.load_row};
    assign wr_ok  = cmd.accept && (req_type == REQ_LOAD) && !item.tex_col[7]
                    && (wcol16 < 16'(TEX_SIZE)) && (wrow16 < 16'(TEX_SIZE));
    assign waddr  = {item.load_tex, wrow16[LOG-1:0], wcol16[LOG-1:0]};

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= item;
        end
    end

    assign height = item_reg.wall_end - item_reg.wall_start;

    twcs_divider #(
        .TEX_SIZE(TEX_SIZE)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start_div),
        .divisor  (height),
        .done     (div_done),
        .quotient (quotient)
    );

    assign base    = 32'(item_reg.wall_start) - HALF_H + 32'(height >> 1);
    assign product = base * quotient;

    // signed 16.16 position truncated toward zero
    assign neg_pos   = 32'd0 - pos_reg;
    assign neg_whole = 16'd0 - neg_pos[31:16];
    assign row       = pos_reg[31] ? neg_whole[LOG-1:0] : pos_reg[16+LOG-1:16];

    assign tex_sel = item_reg.side ? (item_reg.ray_dir_y_pos ? 2'd2 : 2'd3)
                                   : (item_reg.ray_dir_x_pos ? 2'd0 : 2'd1);
    assign col16   = {8'b0, item_reg.tex_col};
    assign col_ok  = !item_reg.tex_col[7] && (col16 < 16'(TEX_SIZE));
    assign raddr   = {tex_sel, row, col16[LOG-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            pos_reg  <= '0;
        end else if (cmd.load_step) begin
            step_reg <= quotient;
            pos_reg  <= product[31:0];
        end else if (cmd.read_tex) begin
            pos_reg  <= pos_reg + step_reg;
        end
    end

    twcs_ram #(
        .WIDTH(32),
        .DEPTH(4 * TEX_SIZE * TEX_SIZE)
    ) u_tex_ram (
        .aclk  (aclk),
        .we    (wr_ok),
        .waddr (waddr),
        .wdata (item.load_color),
        .re    (cmd.read_tex),
        .raddr (raddr),
        .rdata (rdata)
    );

    // x-side walls are darkened
    always_comb begin
        texel = col_ok ? rdata : 32'd0;
        if (!item_reg.side) begin
            texel = (texel >> 1) & SHADE_MASK;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_cfg_color) begin
            color_reg <= status.floor_row ? floor_rgb : ceil_rgb;
        end else if (cmd.take_texel) begin
            color_reg <= texel;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_x_reg     <= item_reg.screen_x;
            out_y_reg     <= item_reg.screen_y;
            out_color_reg <= color_reg;
        end
    end

    assign status.req_draw  = req_type == REQ_DRAW;
    assign status.drop      = 32'(item_reg.screen_y) >= 32'(SCREEN_HEIGHT);
    assign status.floor_row = {1'b0, item_reg.screen_y} >= item_reg.wall_end;
    assign status.ceil_row  = {1'b0, item_reg.screen_y} < item_reg.wall_start;
    assign status.first_row = {1'b0, item_reg.screen_y} == item_reg.wall_start;
    assign status.div_done  = div_done;
    assign status.visible   = (texel != 32'd0) && !texel[31];
    assign status.out_free  = out_free;

    assign m_tvalid  = m_tvalid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_color = out_color_reg;

endmodule

@@ hw/rtl/twcs_ctrl.sv @@
module twcs_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  twcs_pkg::twcs_status_t status,
    output twcs_pkg::twcs_cmd_t    cmd
);
    import twcs_pkg::*;

    twcs_state_t state_reg;
    twcs_state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (status.req_draw) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (status.drop) begin
                    state_next = ST_IDLE;
                end else if (status.floor_row || status.ceil_row) begin
                    cmd.take_cfg_color = 1'b1;
                    state_next         = ST_EMIT;
                end else if (status.first_row) begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.load_step = 1'b1;
                state_next    = ST_READ;
            end
            ST_READ: begin
                cmd.read_tex = 1'b1;
                state_next   = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.take_texel = 1'b1;
                state_next     = status.visible ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/textured_wall_column_shader_unit.sv @@
// Textured wall column shader for a raycaster.
// Input stream (s_*): s_tuser = 0 loads one texel into one of four square
// textures, s_tuser = 1 shades one screen pixel. Draw beats of a column come
// in increasing row order. Result stream (m_*): one beat per visible pixel
// (ceiling, floor, or a wall texel that is positive as a signed word).
// Ceiling and floor colors are to be written over the APB port while idle;
// the block does not enforce it. Steps per input beat, one in flight at a time:
//   load: texel written into texture memory when the beat is accepted
//   row below the screen: checked and dropped
//   ceiling or floor: configured color taken, then emitted
//   wall row: texture read (memory read is registered), texel taken, emitted
//   first wall row of a column: first waits on the radix-2 divider for
//   the texture step, then loads the step and start position
//   a wall row whose pixel is not visible ends after the texel is taken
// A result sits in an output register; the next beat is accepted while it
// waits. If the receiver stalls, a following visible pixel holds the block
// until the register drains. Reset clears the control state, the colors and
// the texture step and position; texture contents stay undefined until loaded.
module textured_wall_column_shader_unit #(
    parameter int TEX_SIZE      = twcs_pkg::TEX_SIZE_DEF,
    parameter int SCREEN_HEIGHT = twcs_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // screen_x, screen_y, wall_start, wall_end, side, ray_dir_x_pos,
    // ray_dir_y_pos, tex_col, load_tex, load_row, load_color, zero pad
    input  logic [twcs_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_x, out_y, out_color, zero pad
    output logic [twcs_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import twcs_pkg::*;

    logic [31:0]  ceil_rgb_reg;
    logic [31:0]  floor_rgb_reg;
    logic         cfg_wr;
    twcs_item_t   item;
    twcs_cmd_t    cmd;
    twcs_status_t status;
    logic [9:0]   out_x;
    logic [8:0]   out_y;
    logic [31:0]  out_color;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ceil_rgb_reg  <= '0;
            floor_rgb_reg <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_CEILING) begin
                ceil_rgb_reg <= pwdata;
            end else begin
                floor_rgb_reg <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == REG_FLOOR) ? floor_rgb_reg : ceil_rgb_reg;

    assign item = twcs_item_t'(s_tdata[ITEM_W-1:0]);

    twcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    twcs_datapath #(
        .TEX_SIZE      (TEX_SIZE),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (item),
        .req_type  (s_tuser),
        .ceil_rgb  (ceil_rgb_reg),
        .floor_rgb (floor_rgb_reg),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_color (out_color)
    );

    assign m_tdata = {5'b0, out_color, out_y, out_x};

endmodule
